/* rtl/core/shd_pkg.sv */
// ----------------------------------------------------------------------------
// shd_pkg
// Shared types and constants of the swept hit detector.
// ----------------------------------------------------------------------------
package shd_pkg;

    localparam int POS_DEPTH_DEF = 512;
    localparam int REC_DEPTH_DEF = 256;

    localparam int CW  = 24;        // coordinate width
    localparam int HW  = 16;        // half size / register width
    localparam int RW  = 18;        // radius width
    localparam int IDW = 32;
    localparam int TW  = 48;
    localparam int SW  = CW + 1;    // coordinate difference width
    localparam int PW  = 2 * SW + 1; // sum of two products
    localparam int MW  = 2 * SW;    // serial multiplier operand width

    localparam int CFG_IW = 3;
    localparam int Q_DEPTH = 2;

    localparam logic [CFG_IW-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_PLAYER_HALF  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_HIT_MARGIN   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DEFAULT_HALF = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_TTL_MS       = 3'd4;

    localparam logic [HW-1:0] RST_PLAYER_HALF  = 16'd876;
    localparam logic [HW-1:0] RST_HIT_MARGIN   = 16'd164;
    localparam logic [HW-1:0] RST_DEFAULT_HALF = 16'd2048;
    localparam logic [HW-1:0] RST_TTL_MS       = 16'd2500;

    typedef struct packed {
        logic                  en;
        logic [IDW-1:0]        bid;
        logic [IDW-1:0]        own;
        logic signed [CW-1:0]  cx;
        logic signed [CW-1:0]  cy;
        logic signed [CW-1:0]  px;
        logic signed [CW-1:0]  py;
        logic [RW-1:0]         radius;
        logic [TW-1:0]         now;
        logic [HW-1:0]         ttl;
    } t_item;

    typedef struct packed {
        logic                  used;
        logic                  seen;
        logic [IDW-1:0]        id;
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
    } t_pos_ent;

    typedef struct packed {
        logic           used;
        logic [IDW-1:0] owner;
        logic [IDW-1:0] bullet;
        logic [TW-1:0]  tms;
    } t_rec_ent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* rtl/core/swept_hit_detect_dedup_unit.sv */
// ----------------------------------------------------------------------------
// swept_hit_detect_dedup_unit
// Swept projectile-versus-player hit detector with duplicate suppression.
// ----------------------------------------------------------------------------
// Usage:
//   An item (one projectile sighting) is taken at a clock edge with start
//   high and busy low. Items go into a two-entry queue; the engine handles
//   one item at a time and gives exactly one result per item, in order, as
//   a single-cycle o_valid strobe with o_hit, o_table_full, o_hit_owner and
//   o_hit_bullet. Results cannot be held off.
//   The engine probes slots in turn, runs a bit-serial wide product when the
//   closest point lies inside the segment and, on a hit, scans the hit record
//   memory. A full slot table is reported once every slot has been probed;
//   a disabled item is answered without a probe. The position and record
//   memory ports and the serial steps set the rate; the engine starts no new
//   item before it has given the result of the last one.
//   POS_DEPTH must be a power of two, which the block does not check: the home slot is the low id bits.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no item is in flight.
//   After reset the block sweeps both tables with busy high; configuration
//   writes are taken meanwhile.
// ----------------------------------------------------------------------------
module swept_hit_detect_dedup_unit
    import shd_pkg::*;
#(
    parameter int POS_DEPTH = POS_DEPTH_DEF,
    parameter int REC_DEPTH = REC_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cfg_we,
    input  logic [CFG_IW-1:0]    i_cfg_idx,
    input  logic [HW-1:0]        i_cfg_data,
    input  logic [IDW-1:0]       i_bullet_id,
    input  logic [IDW-1:0]       i_owner_id,
    input  logic signed [CW-1:0] i_cur_x,
    input  logic signed [CW-1:0] i_cur_y,
    input  logic signed [CW-1:0] i_player_x,
    input  logic signed [CW-1:0] i_player_y,
    input  logic [HW-1:0]        i_runtime_half,
    input  logic [HW-1:0]        i_catalog_half,
    input  logic [TW-1:0]        i_now_ms,
    output logic                 o_valid,
    output logic                 o_hit,
    output logic                 o_table_full,
    output logic [IDW-1:0]       o_hit_owner,
    output logic [IDW-1:0]       o_hit_bullet
);

    t_item   f_item;
    t_item   q_item;
    logic    f_push;
    logic    pop;
    logic    clearing;
    t_q_stat qstat;

    assign busy = qstat.full || clearing;

    shd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_push         (start && !busy),
        .i_bullet_id    (i_bullet_id),
        .i_owner_id     (i_owner_id),
        .i_cur_x        (i_cur_x),
        .i_cur_y        (i_cur_y),
        .i_player_x     (i_player_x),
        .i_player_y     (i_player_y),
        .i_runtime_half (i_runtime_half),
        .i_catalog_half (i_catalog_half),
        .i_now_ms       (i_now_ms),
        .o_push         (f_push),
        .o_item         (f_item)
    );

    shd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (qstat)
    );

    shd_back #(
        .POS_DEPTH (POS_DEPTH),
        .REC_DEPTH (REC_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_valid      (o_valid),
        .o_hit        (o_hit),
        .o_table_full (o_table_full),
        .o_hit_owner  (o_hit_owner),
        .o_hit_bullet (o_hit_bullet)
    );

endmodule

/* rtl/core/shd_front.sv */
// ----------------------------------------------------------------------------
// shd_front
// Configuration registers and item intake: picks the half size, forms the
// effective radius and packs the item for the queue.
// ----------------------------------------------------------------------------
module shd_front
    import shd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IW-1:0]    i_cfg_idx,
    input  logic [HW-1:0]        i_cfg_data,
    input  logic                 i_push,
    input  logic [IDW-1:0]       i_bullet_id,
    input  logic [IDW-1:0]       i_owner_id,
    input  logic signed [CW-1:0] i_cur_x,
    input  logic signed [CW-1:0] i_cur_y,
    input  logic signed [CW-1:0] i_player_x,
    input  logic signed [CW-1:0] i_player_y,
    input  logic [HW-1:0]        i_runtime_half,
    input  logic [HW-1:0]        i_catalog_half,
    input  logic [TW-1:0]        i_now_ms,
    output logic                 o_push,
    output t_item                o_item
);

    logic          r_enable;
    logic [HW-1:0] r_player_half;
    logic [HW-1:0] r_hit_margin;
    logic [HW-1:0] r_default_half;
    logic [HW-1:0] r_ttl_ms;
    logic [HW-1:0] half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b1;
            r_player_half  <= RST_PLAYER_HALF;
            r_hit_margin   <= RST_HIT_MARGIN;
            r_default_half <= RST_DEFAULT_HALF;
            r_ttl_ms       <= RST_TTL_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE:       r_enable       <= i_cfg_data[0];
                CFG_PLAYER_HALF:  r_player_half  <= i_cfg_data;
                CFG_HIT_MARGIN:   r_hit_margin   <= i_cfg_data;
                CFG_DEFAULT_HALF: r_default_half <= i_cfg_data;
                CFG_TTL_MS:       r_ttl_ms       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (i_runtime_half != '0) half = i_runtime_half;
        else if (i_catalog_half != '0)     half = i_catalog_half;
        else                               half = r_default_half;
    end

    assign o_push        = i_push;
    assign o_item.en     = r_enable;
    assign o_item.bid    = i_bullet_id;
    assign o_item.own    = i_owner_id;
    assign o_item.cx     = i_cur_x;
    assign o_item.cy     = i_cur_y;
    assign o_item.px     = i_player_x;
    assign o_item.py     = i_player_y;
    assign o_item.radius = RW'(half) + RW'(r_player_half) + RW'(r_hit_margin);
    assign o_item.now    = i_now_ms;
    assign o_item.ttl    = r_ttl_ms;

endmodule

/* rtl/core/shd_queue.sv */
// ----------------------------------------------------------------------------
// shd_queue
// Short item FIFO between intake and the processing engine.
// ----------------------------------------------------------------------------
module shd_queue
    import shd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    localparam int AW = $clog2(Q_DEPTH);
    localparam int NW = $clog2(Q_DEPTH + 1);

    t_item         r_mem [Q_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [NW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_cnt == NW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + NW'(do_push) - NW'(do_pop);
        end
    end

endmodule

/* rtl/core/shd_back.sv */
// ----------------------------------------------------------------------------
// shd_back
// Processing engine: slot probe, swept distance test, hit record scan,
// table updates and result output.
// ----------------------------------------------------------------------------
module shd_back
    import shd_pkg::*;
#(
    parameter int POS_DEPTH = POS_DEPTH_DEF,
    parameter int REC_DEPTH = REC_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_item          i_item,
    input  t_q_stat        i_qstat,
    output logic           o_pop,
    output logic           o_clearing,
    output logic           o_valid,
    output logic           o_hit,
    output logic           o_table_full,
    output logic [IDW-1:0] o_hit_owner,
    output logic [IDW-1:0] o_hit_bullet
);

    localparam int PAW  = $clog2(POS_DEPTH);
    localparam int PCW  = $clog2(POS_DEPTH + 1);
    localparam int RAW  = $clog2(REC_DEPTH);
    localparam int RCW  = $clog2(REC_DEPTH + 1);
    localparam int MAXD = (POS_DEPTH > REC_DEPTH) ? POS_DEPTH : REC_DEPTH;
    localparam int CCW  = $clog2(MAXD + 1);
    localparam int KW   = $clog2(MW + 1);
    localparam int NPROD = 11;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_PRD  = 4'd3;
    localparam logic [3:0] S_PCMP = 4'd4;
    localparam logic [3:0] S_DIFF = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_DEC  = 4'd8;
    localparam logic [3:0] S_SER  = 4'd9;
    localparam logic [3:0] S_SCAN = 4'd10;
    localparam logic [3:0] S_RWR  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;

    t_pos_ent pos_mem [POS_DEPTH];
    t_rec_ent rec_mem [REC_DEPTH];
    t_pos_ent r_pos_q;
    t_rec_ent r_rec_q;

    logic [3:0]     r_state;
    t_item          r_it;
    logic [CCW-1:0] r_cc;
    logic [PAW-1:0] r_idx;
    logic [PCW-1:0] r_pc;
    logic signed [CW-1:0] r_ax;
    logic signed [CW-1:0] r_ay;
    logic signed [SW-1:0] r_dx, r_dy, r_wx, r_wy, r_ex, r_ey;
    logic [KW-1:0]  r_k;
    logic signed [SW-1:0]   ma, mb;
    logic signed [2*SW-1:0] prod;
    logic signed [2*SW-1:0] r_p [NPROD];
    logic signed [PW-1:0] r_l2, r_dot, r_da, r_db, r_cr, r_rr;
    logic [2*MW-1:0] r_mc1, r_mc2, r_acc1, r_acc2;
    logic [MW-1:0]   r_ml1, r_ml2;
    logic [RCW-1:0]  r_ri;
    logic [RAW-1:0]  r_rj;
    logic            r_rv;
    logic            r_dup;
    logic            r_pick_v;
    logic [RAW-1:0]  r_pick;
    logic [RAW-1:0]  r_min_i;
    logic [TW-1:0]   r_min_t;
    logic            r_wpos;
    logic [TW-1:0]   age;
    logic            fresh;
    logic [PW-1:0]   cmag;

    logic           pos_we;
    logic [PAW-1:0] pos_wa;
    t_pos_ent       pos_wd;
    logic           rec_we;
    logic [RAW-1:0] rec_wa;
    t_rec_ent       rec_wd;

    // table ports
    always_comb begin
        pos_we = 1'b0;
        pos_wa = r_idx;
        pos_wd = '{used: 1'b1, seen: 1'b1, id: r_it.bid, x: r_it.cx, y: r_it.cy};
        rec_we = 1'b0;
        rec_wa = r_pick_v ? r_pick : r_min_i;
        rec_wd = '{used: 1'b1, owner: r_it.own, bullet: r_it.bid, tms: r_it.now};
        if (r_state == S_CLR) begin
            pos_we = (r_cc < CCW'(POS_DEPTH));
            pos_wa = r_cc[PAW-1:0];
            pos_wd = '0;
            rec_we = (r_cc < CCW'(REC_DEPTH));
            rec_wa = r_cc[RAW-1:0];
            rec_wd = '0;
        end else begin
            pos_we = (r_state == S_FIN) && r_wpos;
            rec_we = (r_state == S_RWR) && !r_dup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
        end
        r_pos_q <= pos_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            rec_mem[rec_wa] <= rec_wd;
        end
        r_rec_q <= rec_mem[r_ri[RAW-1:0]];
    end

    // shared signed multiplier, one product per step
    always_comb begin
        unique case (r_k)
            KW'(0):  begin ma = r_dx; mb = r_dx; end
            KW'(1):  begin ma = r_dy; mb = r_dy; end
            KW'(2):  begin ma = r_wx; mb = r_dx; end
            KW'(3):  begin ma = r_wy; mb = r_dy; end
            KW'(4):  begin ma = r_wx; mb = r_wx; end
            KW'(5):  begin ma = r_wy; mb = r_wy; end
            KW'(6):  begin ma = r_ex; mb = r_ex; end
            KW'(7):  begin ma = r_ey; mb = r_ey; end
            KW'(8):  begin ma = r_wx; mb = r_dy; end
            KW'(9):  begin ma = r_wy; mb = r_dx; end
            KW'(10): begin
                ma = $signed({{(SW-RW){1'b0}}, r_it.radius});
                mb = $signed({{(SW-RW){1'b0}}, r_it.radius});
            end
            default: begin ma = '0; mb = '0; end
        endcase
    end
    assign prod = ma * mb;

    assign age    = r_it.now - r_rec_q.tms;
    assign fresh  = r_rec_q.used && (r_it.now >= r_rec_q.tms) && (age < TW'(r_it.ttl));
    assign cmag   = r_cr[PW-1] ? PW'(-r_cr) : PW'(r_cr);

    assign o_pop      = (r_state == S_IDLE) && !i_qstat.empty;
    assign o_clearing = (r_state == S_CLR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cc    <= '0;
            r_idx   <= '0;
            r_ri    <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_cc <= r_cc + 1'b1;
                    if (r_cc == CCW'(MAXD - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_it   <= i_item;
                        // home slot: low id bits; depth must be a power of two, unchecked
                        r_idx  <= i_item.bid[PAW-1:0];
                        r_pc   <= '0;
                        r_wpos <= 1'b0;
                        r_dup  <= 1'b0;
                        o_hit        <= 1'b0;
                        o_table_full <= 1'b0;
                        o_hit_owner  <= '0;
                        o_hit_bullet <= '0;
                        r_state <= i_item.en ? S_PRD : S_FIN;
                    end
                end
                S_PRD: begin
                    // slot read in flight
                    r_state <= S_PCMP;
                end
                S_PCMP: begin
                    if (r_pos_q.used && r_pos_q.id == r_it.bid) begin
                        r_ax    <= r_pos_q.seen ? r_pos_q.x : r_it.cx;
                        r_ay    <= r_pos_q.seen ? r_pos_q.y : r_it.cy;
                        r_wpos  <= 1'b1;
                        r_state <= S_DIFF;
                    end else if (!r_pos_q.used) begin
                        r_ax    <= r_it.cx;
                        r_ay    <= r_it.cy;
                        r_wpos  <= 1'b1;
                        r_state <= S_DIFF;
                    end else if (r_pc == PCW'(POS_DEPTH - 1)) begin
                        o_table_full <= 1'b1;
                        r_state      <= S_FIN;
                    end else begin
                        r_idx   <= (r_idx == PAW'(POS_DEPTH - 1)) ? '0 : r_idx + 1'b1;
                        r_pc    <= r_pc + 1'b1;
                        r_state <= S_PRD;
                    end
                end
                S_DIFF: begin
                    r_dx <= SW'(r_it.cx) - SW'(r_ax);
                    r_dy <= SW'(r_it.cy) - SW'(r_ay);
                    r_wx <= SW'(r_it.px) - SW'(r_ax);
                    r_wy <= SW'(r_it.py) - SW'(r_ay);
                    r_ex <= SW'(r_it.px) - SW'(r_it.cx);
                    r_ey <= SW'(r_it.py) - SW'(r_it.cy);
                    r_k  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p[r_k[3:0]] <= prod;
                    r_k <= r_k + 1'b1;
                    if (r_k == KW'(NPROD - 1)) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_l2  <= PW'(r_p[0]) + PW'(r_p[1]);
                    r_dot <= PW'(r_p[2]) + PW'(r_p[3]);
                    r_da  <= PW'(r_p[4]) + PW'(r_p[5]);
                    r_db  <= PW'(r_p[6]) + PW'(r_p[7]);
                    r_cr  <= PW'(r_p[8]) - PW'(r_p[9]);
                    r_rr  <= PW'(r_p[10]);
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_ri     <= '0;
                    r_rv     <= 1'b0;
                    r_pick_v <= 1'b0;
                    r_dup    <= 1'b0;
                    if (r_l2 == '0 || r_dot[PW-1] || r_dot == '0) begin
                        r_state <= (r_da < r_rr) ? S_SCAN : S_FIN;
                    end else if (r_dot >= r_l2) begin
                        r_state <= (r_db < r_rr) ? S_SCAN : S_FIN;
                    end else begin
                        r_mc1  <= (2*MW)'(cmag[MW-1:0]);
                        r_ml1  <= cmag[MW-1:0];
                        r_mc2  <= (2*MW)'(r_l2[MW-1:0]);
                        r_ml2  <= r_rr[MW-1:0];
                        r_acc1 <= '0;
                        r_acc2 <= '0;
                        r_k    <= '0;
                        r_state <= S_SER;
                    end
                end
                S_SER: begin
                    // c*c against rr*l2, shift-add one bit a cycle
                    if (r_ml1[0]) r_acc1 <= r_acc1 + r_mc1;
                    if (r_ml2[0]) r_acc2 <= r_acc2 + r_mc2;
                    r_mc1 <= r_mc1 << 1;
                    r_mc2 <= r_mc2 << 1;
                    r_ml1 <= r_ml1 >> 1;
                    r_ml2 <= r_ml2 >> 1;
                    r_k   <= r_k + 1'b1;
                    if (r_k == KW'(MW)) begin
                        r_state <= (r_acc1 < r_acc2) ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    if (r_ri < RCW'(REC_DEPTH)) begin
                        r_ri <= r_ri + 1'b1;
                    end
                    r_rv <= (r_ri < RCW'(REC_DEPTH));
                    r_rj <= r_ri[RAW-1:0];
                    if (r_rv) begin
                        if (fresh && r_rec_q.owner == r_it.own
                                  && r_rec_q.bullet == r_it.bid) begin
                            r_dup <= 1'b1;
                        end
                        if (!fresh && !r_pick_v) begin
                            r_pick_v <= 1'b1;
                            r_pick   <= r_rj;
                        end
                        if (r_rj == '0 || r_rec_q.tms < r_min_t) begin
                            r_min_t <= r_rec_q.tms;
                            r_min_i <= r_rj;
                        end
                        if (r_rj == RAW'(REC_DEPTH - 1)) begin
                            r_state <= S_RWR;
                        end
                    end
                end
                S_RWR: begin
                    if (!r_dup) begin
                        o_hit        <= 1'b1;
                        o_hit_owner  <= r_it.own;
                        o_hit_bullet <= r_it.bid;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* tb/sv/tb_swept_hit_detect_dedup_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swept_hit_detect_dedup_unit
// Drives projectile sightings into the swept hit detector and compares every
// result strobe against an in-bench predictor of the position table, the
// swept distance test and the recent-hits table. Covers the register
// settings, idle gaps, duplicate suppression, eviction and a full table.
// ----------------------------------------------------------------------------
module tb_swept_hit_detect_dedup_unit;
    import shd_pkg::*;

    localparam int NPOS = POS_DEPTH_DEF;
    localparam int NREC = REC_DEPTH_DEF;
    localparam longint LIMIT = 10000000;

    typedef struct packed {
        logic [IDW-1:0]       bid;
        logic [IDW-1:0]       own;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic [HW-1:0]        rh;
        logic [HW-1:0]        ch;
        logic [TW-1:0]        now;
    } t_shot;

    typedef struct packed {
        logic           hit;
        logic           full;
        logic [IDW-1:0] owner;
        logic [IDW-1:0] bullet;
    } t_verdict;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_cfg_we;
    logic [CFG_IW-1:0]    i_cfg_idx;
    logic [HW-1:0]        i_cfg_data;
    logic [IDW-1:0]       i_bullet_id;
    logic [IDW-1:0]       i_owner_id;
    logic signed [CW-1:0] i_cur_x;
    logic signed [CW-1:0] i_cur_y;
    logic signed [CW-1:0] i_player_x;
    logic signed [CW-1:0] i_player_y;
    logic [HW-1:0]        i_runtime_half;
    logic [HW-1:0]        i_catalog_half;
    logic [TW-1:0]        i_now_ms;
    logic                 o_valid;
    logic                 o_hit;
    logic                 o_table_full;
    logic [IDW-1:0]       o_hit_owner;
    logic [IDW-1:0]       o_hit_bullet;

    swept_hit_detect_dedup_unit u_top (.*);

    // predictor state
    logic           en_q;
    logic [HW-1:0]  ph_q, hm_q, dh_q, ttl_q;
    logic           slot_used [NPOS];
    logic           slot_seen [NPOS];
    logic [IDW-1:0] slot_id   [NPOS];
    longint         slot_x    [NPOS];
    longint         slot_y    [NPOS];
    logic           hit_used  [NREC];
    logic [IDW-1:0] hit_owner [NREC];
    logic [IDW-1:0] hit_bull  [NREC];
    logic [TW-1:0]  hit_time  [NREC];

    t_verdict verdicts_due[$];
    int       n_err, n_items, n_hits, n_full;
    longint   n_cyc = 0;
    bit       idle_on;
    logic [IDW-1:0] bid_pool [32];
    logic [IDW-1:0] own_pool [4];
    logic [TW-1:0]  clock_ms;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        n_cyc <= n_cyc + 1;
        if (n_cyc > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic bit seg_close(longint px, longint py, longint ax, longint ay,
                                     longint bx, longint by, longint r);
        longint dx, dy, wx, wy, l2, dot, rr, ex, ey, cr;
        logic [127:0] c, lhs, rhs;
        dx = bx - ax; dy = by - ay;
        wx = px - ax; wy = py - ay;
        l2 = dx * dx + dy * dy;
        dot = wx * dx + wy * dy;
        rr = r * r;
        if (l2 == 0 || dot <= 0) return (wx * wx + wy * wy) < rr;
        if (dot >= l2) begin
            ex = px - bx; ey = py - by;
            return (ex * ex + ey * ey) < rr;
        end
        cr = wx * dy - wy * dx;
        c = (cr < 0) ? -cr : cr;
        lhs = c * c;
        rhs = 128'(rr) * 128'(l2);
        return lhs < rhs;
    endfunction

    function automatic bit is_fresh(int i, logic [TW-1:0] now);
        return hit_used[i] && now >= hit_time[i] && (now - hit_time[i]) < ttl_q;
    endfunction

    function automatic t_verdict predict_shot(t_shot s);
        t_verdict v;
        int slot, i, pick, oldest;
        longint ax, ay;
        logic [RW-1:0] radius;
        logic [HW-1:0] half;
        bit dup;
        v = '0;
        if (!en_q) return v;
        slot = -1;
        i = s.bid[8:0];
        for (int n = 0; n < NPOS; n++) begin
            if (slot_used[i] && slot_id[i] == s.bid) begin
                slot = i;
                break;
            end
            if (!slot_used[i]) begin
                slot_used[i] = 1'b1;
                slot_seen[i] = 1'b0;
                slot_id[i] = s.bid;
                slot = i;
                break;
            end
            i = (i + 1) % NPOS;
        end
        if (slot < 0) begin
            v.full = 1'b1;
            return v;
        end
        ax = slot_seen[slot] ? slot_x[slot] : longint'(s.cx);
        ay = slot_seen[slot] ? slot_y[slot] : longint'(s.cy);
        half = (s.rh != 0) ? s.rh : ((s.ch != 0) ? s.ch : dh_q);
        radius = RW'(half) + RW'(ph_q) + RW'(hm_q);
        if (seg_close(s.px, s.py, ax, ay, s.cx, s.cy, longint'(radius))) begin
            dup = 0;
            for (i = 0; i < NREC; i++)
                if (is_fresh(i, s.now) && hit_owner[i] == s.own && hit_bull[i] == s.bid) begin
                    dup = 1;
                    break;
                end
            if (!dup) begin
                pick = -1;
                oldest = 0;
                for (i = 0; i < NREC; i++) begin
                    if (!is_fresh(i, s.now)) begin
                        pick = i;
                        break;
                    end
                    if (hit_time[i] < hit_time[oldest]) oldest = i;
                end
                if (pick < 0) pick = oldest;
                hit_used[pick] = 1'b1;
                hit_owner[pick] = s.own;
                hit_bull[pick] = s.bid;
                hit_time[pick] = s.now;
                v.hit = 1'b1;
                v.owner = s.own;
                v.bullet = s.bid;
            end
        end
        slot_x[slot] = s.cx;
        slot_y[slot] = s.cy;
        slot_seen[slot] = 1'b1;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict e;
        if (i_rst_n && o_valid) begin
            if (verdicts_due.size() == 0) begin
                $error("result with no item pending");
                n_err++;
            end else begin
                e = verdicts_due.pop_front();
                if (o_hit !== e.hit) begin
                    $error("hit: expected %0h actual %0h", e.hit, o_hit);
                    n_err++;
                end
                if (o_table_full !== e.full) begin
                    $error("table_full: expected %0h actual %0h", e.full, o_table_full);
                    n_err++;
                end
                if (o_hit_owner !== e.owner) begin
                    $error("hit_owner: expected %0h actual %0h", e.owner, o_hit_owner);
                    n_err++;
                end
                if (o_hit_bullet !== e.bullet) begin
                    $error("hit_bullet: expected %0h actual %0h", e.bullet, o_hit_bullet);
                    n_err++;
                end
            end
        end
    end

    function automatic t_shot mk(logic [IDW-1:0] bid, logic [IDW-1:0] own,
                                 int cx, int cy, int px, int py,
                                 int rh, int ch, logic [TW-1:0] now);
        t_shot s;
        s.bid = bid; s.own = own;
        s.cx = CW'(cx); s.cy = CW'(cy); s.px = CW'(px); s.py = CW'(py);
        s.rh = HW'(rh); s.ch = HW'(ch); s.now = now;
        return s;
    endfunction

    // sits at a rising edge on return; start stays high for a back-to-back item
    task automatic send_shot(t_shot s);
        t_verdict v;
        i_bullet_id <= s.bid;
        i_owner_id <= s.own;
        i_cur_x <= s.cx;
        i_cur_y <= s.cy;
        i_player_x <= s.px;
        i_player_y <= s.py;
        i_runtime_half <= s.rh;
        i_catalog_half <= s.ch;
        i_now_ms <= s.now;
        start <= 1'b1;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        v = predict_shot(s);
        verdicts_due.push_back(v);
        n_items++;
        n_hits += v.hit;
        n_full += v.full;
    endtask

    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [HW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_ENABLE:       en_q = val[0];
            CFG_PLAYER_HALF:  ph_q = val;
            CFG_HIT_MARGIN:   hm_q = val;
            CFG_DEFAULT_HALF: dh_q = val;
            CFG_TTL_MS:       ttl_q = val;
            default: ;
        endcase
    endtask

    task automatic set_cfg(int en, int ph, int hm, int dh, int ttl);
        drain();
        cfg_write(CFG_ENABLE, HW'(en));
        cfg_write(CFG_PLAYER_HALF, HW'(ph));
        cfg_write(CFG_HIT_MARGIN, HW'(hm));
        cfg_write(CFG_DEFAULT_HALF, HW'(dh));
        cfg_write(CFG_TTL_MS, HW'(ttl));
    endtask

    function automatic t_shot rand_shot();
        t_shot s;
        int off;
        if ($urandom_range(0, 9) == 0) begin
            s.bid = $urandom; s.own = $urandom;
            s.cx = CW'($urandom); s.cy = CW'($urandom);
            s.px = CW'($urandom); s.py = CW'($urandom);
            s.rh = HW'($urandom); s.ch = HW'($urandom);
            s.now = TW'({$urandom, $urandom});
            return s;
        end
        s.bid = bid_pool[$urandom_range(0, 31)];
        s.own = own_pool[$urandom_range(0, 3)];
        s.px = CW'($urandom_range(0, 1 << 23) - (1 << 22));
        s.py = CW'($urandom_range(0, 1 << 23) - (1 << 22));
        off = $urandom_range(0, 24000);
        s.cx = CW'(s.px + off - 12000);
        off = $urandom_range(0, 24000);
        s.cy = CW'(s.py + off - 12000);
        case ($urandom_range(0, 2))
            0: begin s.rh = HW'($urandom_range(1, 8000)); s.ch = HW'($urandom); end
            1: begin s.rh = '0; s.ch = HW'($urandom_range(0, 8000)); end
            default: begin s.rh = '0; s.ch = '0; end
        endcase
        clock_ms += TW'($urandom_range(0, 900));
        s.now = clock_ms;
        return s;
    endfunction

    task automatic test_directed();
        int ext;
        ext = -8388608;
        // point test on first sighting, repeat within ttl, repeat after ttl
        send_shot(mk(32'h1, 32'hA, 0, 0, 0, 0, 0, 0, 1000));
        send_shot(mk(32'h1, 32'hA, 0, 0, 0, 0, 0, 0, 1500));
        send_shot(mk(32'h1, 32'hA, 0, 0, 0, 0, 0, 0, 3500));
        // sweep through the player, closest point inside the segment
        send_shot(mk(32'h2, 32'hA, -20000, 0, 0, 0, 0, 0, 4000));
        send_shot(mk(32'h2, 32'hA, 20000, 100, 0, 0, 0, 0, 4001));
        // moving away, then to exactly the radius, then just inside
        send_shot(mk(32'h3, 32'hB, 5000, 0, 0, 0, 0, 0, 4002));
        send_shot(mk(32'h3, 32'hB, 9000, 0, 0, 0, 0, 0, 4003));
        send_shot(mk(32'h3, 32'hB, 3088, 0, 0, 0, 0, 0, 4004));
        send_shot(mk(32'h3, 32'hB, 3087, 0, 0, 0, 0, 0, 4005));
        // half size selection
        send_shot(mk(32'h4, 32'hB, 1041, 0, 0, 0, 1, 60000, 4006));
        send_shot(mk(32'h5, 32'hB, 60000, 0, 0, 0, 0, 60000, 4007));
        // extremes, slot collision with wrap of the id mask
        send_shot(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, ext, 8388607, 8388607, ext,
                     16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF));
        send_shot(mk(32'h8000_0000, 32'h0, ext, 8388607, ext, 8388607, 0, 0, 0));
        send_shot(mk(32'h8000_0001, 32'h0, 0, 0, 0, 0, 0, 0, 0));
        send_shot(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8388607, ext, 8388607, ext,
                     16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF));
        // record in the future counts as stale
        send_shot(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8388607, ext, 8388607, ext,
                     0, 0, 5));
        // disabled
        set_cfg(0, 876, 164, 2048, 2500);
        send_shot(mk(32'h6, 32'hC, 0, 0, 0, 0, 0, 0, 6000));
        send_shot(mk(32'h1, 32'hA, 0, 0, 0, 0, 0, 0, 6000));
        // ttl of zero never suppresses
        set_cfg(1, 876, 164, 2048, 0);
        send_shot(mk(32'h6, 32'hC, 0, 0, 0, 0, 0, 0, 7000));
        send_shot(mk(32'h6, 32'hC, 0, 0, 0, 0, 0, 0, 7000));
        send_shot(mk(32'h6, 32'hC, 0, 0, 0, 0, 0, 0, 7000));
        drain();
    endtask

    task automatic test_random(int n);
        repeat (n) begin
            send_shot(rand_shot());
            maybe_gap();
        end
    endtask

    // fill the hit records past capacity, then the position table
    task automatic test_fill();
        logic [IDW-1:0] base;
        t_shot s;
        base = {$urandom, 9'd0};
        set_cfg(1, 876, 164, 2048, 16'hFFFF);
        for (int k = 0; k < 520; k++) begin
            s = mk(base + k, 32'h77, k * 16, 0, k * 16, 0, 0, 0, 48'h1_0000_0000);
            send_shot(s);
            maybe_gap();
        end
        for (int k = 0; k < 6; k++)
            send_shot(mk($urandom, 32'h78, 0, 0, 0, 0, 0, 0, 48'h1_0000_0001));
        send_shot(mk(base + 3, 32'h77, 0, 0, 0, 0, 0, 0, 48'h1_0000_0002));
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_bullet_id = '0;
        i_owner_id = '0;
        i_cur_x = '0;
        i_cur_y = '0;
        i_player_x = '0;
        i_player_y = '0;
        i_runtime_half = '0;
        i_catalog_half = '0;
        i_now_ms = '0;
        n_err = 0; n_items = 0; n_hits = 0; n_full = 0;
        idle_on = 1;
        clock_ms = 48'd100000;
        en_q = 1'b1;
        ph_q = RST_PLAYER_HALF;
        hm_q = RST_HIT_MARGIN;
        dh_q = RST_DEFAULT_HALF;
        ttl_q = RST_TTL_MS;
        for (int i = 0; i < NPOS; i++) begin
            slot_used[i] = 0; slot_seen[i] = 0; slot_id[i] = 0;
            slot_x[i] = 0; slot_y[i] = 0;
        end
        for (int i = 0; i < NREC; i++) begin
            hit_used[i] = 0; hit_owner[i] = 0; hit_bull[i] = 0; hit_time[i] = 0;
        end
        for (int i = 0; i < 32; i++) bid_pool[i] = $urandom;
        for (int i = 0; i < 4; i++) own_pool[i] = $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_cfg(1, 876, 164, 2048, 2500);
        test_random(150);
        set_cfg(1, 0, 0, 0, 65535);
        test_random(100);
        set_cfg(1, 65535, 65535, 65535, 1000);
        test_random(100);
        set_cfg(0, 3000, 500, 4000, 2000);
        test_random(30);
        set_cfg(1, $urandom_range(0, 5000), $urandom_range(0, 2000),
                $urandom_range(0, 6000), $urandom_range(0, 4000));
        test_random(100);
        drain();
        test_random(40);
        idle_on = 0;
        set_cfg(1, 876, 164, 2048, 2500);
        test_random(130);
        test_fill();

        start <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("%0d sightings over several register settings: %0d hits, %0d table full",
                 n_items, n_hits, n_full);
        $display("covered duplicates, ttl expiry, record eviction and a full slot table");
        if (n_err == 0 && verdicts_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
